>>> hw/rtl/plcr_pkg.sv
// Package for the priority layered claim resolver.
// Holds table sizing, command/status/register codes and the rank unit structs.
// No dependencies.
package plcr_pkg;

    localparam int MAX_CLAIMS = 8;
    localparam int SLOT_W     = $clog2(MAX_CLAIMS);
    localparam int CNT_W      = $clog2(MAX_CLAIMS + 1);
    localparam int ENTRY_W    = 64;   // {serial, request}
    localparam int LANES      = 4;    // style, mode, shoulder, owner

    // lane numbers inside the rank unit
    localparam int LANE_STYLE    = 0;
    localparam int LANE_MODE     = 1;
    localparam int LANE_SHOULDER = 2;
    localparam int LANE_OWNER    = 3;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_UPDATE  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_INVALID   = 2'd3;

    localparam logic [1:0] REG_BASE_STYLE    = 2'd0;
    localparam logic [1:0] REG_BASE_MODE     = 2'd1;
    localparam logic [1:0] REG_BASE_SHOULDER = 2'd2;

    typedef struct packed {
        logic clear;    // drop all lane winners
        logic sample;   // offer the candidate entry to every lane
    } rank_ctl_t;

    typedef struct packed {
        logic [LANES-1:0]       found;
        logic [LANES-1:0][31:0] req;
    } rank_t;

endpackage

>>> hw/rtl/plcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plcr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/plcr_rank.sv
// Shared rank unit: keeps the strongest claim seen so far for each resolved field
// and for the owner, one candidate entry per cycle. Depends on plcr_pkg.
module plcr_rank (
    input  logic                clk,
    input  logic                rst_n,
    input  plcr_pkg::rank_ctl_t ctl,
    input  logic [31:0]         cand_req,
    input  logic [31:0]         cand_serial,
    output plcr_pkg::rank_t     best
);
    import plcr_pkg::*;

    logic [LANES-1:0]       found_reg;
    logic [LANES-1:0][31:0] req_reg;
    logic [31:0]            serial_reg [LANES];
    logic [LANES-1:0]       take;

    // higher priority wins, then higher serial; a tie keeps the earlier slot
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic eligible;
            logic stronger;
            if (l == LANE_OWNER)
            begin
                eligible = 1'b1;
            end
            else
            begin
                eligible = (cand_req[27 - 4*l -: 4] != 4'd0);
            end
            if (cand_req[31:28] != req_reg[l][31:28])
            begin
                stronger = (cand_req[31:28] > req_reg[l][31:28]);
            end
            else
            begin
                stronger = (cand_serial > serial_reg[l]);
            end
            take[l] = ctl.sample && eligible && (!found_reg[l] || stronger);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
        end
        else if (ctl.clear)
        begin
            found_reg <= '0;
        end
        else
        begin
            found_reg <= found_reg | take;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (take[l])
            begin
                req_reg[l]    <= cand_req;
                serial_reg[l] <= cand_serial;
            end
        end
    end

    assign best.found = found_reg;
    assign best.req   = req_reg;

endmodule

>>> hw/rtl/priority_layered_claim_resolver.sv
// Top level of the priority layered claim resolver: command sequencer, claim
// table, base registers and APB port. Depends on plcr_pkg, plcr_ram, plcr_rank.
//
// Usage:
//   Command beats enter on cmd_valid/cmd_stall (add, release, update); each one
//   yields exactly one result beat on res_valid/res_stall carrying status, the
//   issued handle and the resolved style, mode, shoulder, owner and revision.
//   The block handles one command at a time and holds cmd_stall high from the
//   accepted beat until its result beat has been taken.
//   A command is first matched against the table in one pass over its
//   MAX_CLAIMS slots (the table RAM read being registered), then a successful
//   command is resolved by a second pass through the shared rank unit and a
//   finishing state. A failed command skips the second pass; handle zero and
//   unknown codes go straight to the finishing state. The next command can be
//   taken in the cycle after the result is taken. Reset empties the table,
//   zeroes the serial counter, the revision and the base registers. While
//   res_stall is high the result holds and no new command is taken. Base
//   registers are to be written over APB only while idle (the block itself does
//   not enforce this) and take effect at the next successful command.
module priority_layered_claim_resolver (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  command,
    input  logic [31:0] handle,
    input  logic [3:0]  priority_req,
    input  logic [3:0]  style,
    input  logic [3:0]  mode,
    input  logic [3:0]  shoulder,
    input  logic [15:0] reason,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic [31:0] new_handle,
    output logic [3:0]  out_style,
    output logic [3:0]  out_mode,
    output logic [3:0]  out_shoulder,
    output logic [3:0]  owner_priority,
    output logic [15:0] owner_reason,
    output logic        changed,
    output logic [31:0] revision,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import plcr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_MATCH   = 4'b0010,
        ST_RESOLVE = 4'b0100,
        ST_FINISH  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [MAX_CLAIMS-1:0] valid_reg;
    logic [1:0]            cmd_reg;
    logic [31:0]           handle_reg;
    logic [31:0]           req_reg;
    logic                  found_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  ok_reg;
    logic [1:0]            stat_reg;
    logic [31:0]           issued_reg;
    logic [31:0]           serial_reg;
    logic [31:0]           resolved_reg;
    logic [31:0]           revision_reg;
    logic [3:0]            base_style_reg;
    logic [3:0]            base_mode_reg;
    logic [3:0]            base_shoulder_reg;
    logic                  res_valid_reg;
    logic [1:0]            res_status_reg;
    logic [31:0]           res_handle_reg;
    logic                  res_changed_reg;

    logic                  accept;
    logic                  cfg_write;
    logic [CNT_W-1:0]      cnt_m1;
    logic [SLOT_W-1:0]     slot_cur;
    logic                  have_data;
    logic                  last;
    logic [ENTRY_W-1:0]    rd_data;
    logic [31:0]           rd_serial;
    logic [31:0]           rd_req;
    logic                  hit;
    logic                  found_now;
    logic [SLOT_W-1:0]     slot_now;
    logic                  ok_now;
    logic [31:0]           serial_inc;
    logic [31:0]           serial_new;
    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    rank_ctl_t             rank_ctl;
    rank_t                 best;
    logic [31:0]           resolved_next;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE) || res_valid_reg;
    assign cfg_write = psel && penable && pwrite && pready;

    // data on the RAM output belongs to the slot addressed in the previous cycle
    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign slot_cur  = cnt_m1[SLOT_W-1:0];
    assign have_data = (cnt_reg != '0);
    assign last      = (cnt_reg == CNT_W'(MAX_CLAIMS));
    assign rd_serial = rd_data[63:32];
    assign rd_req    = rd_data[31:0];
    assign hit       = have_data && valid_reg[slot_cur] && (rd_serial == handle_reg);

    assign found_now = found_reg || (have_data && !valid_reg[slot_cur]);
    assign slot_now  = found_reg ? slot_reg : slot_cur;

    assign serial_inc = serial_reg + 32'd1;
    assign serial_new = (serial_inc == 32'd0) ? 32'd1 : serial_inc;

    always_comb
    begin
        case (cmd_reg)
            CMD_ADD:     ok_now = found_now;
            CMD_RELEASE: ok_now = ok_reg || hit;
            CMD_UPDATE:  ok_now = ok_reg || hit;
            default:     ok_now = 1'b0;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot_cur;
        ram_wdata = {rd_serial, req_reg};
        if (state_reg == ST_MATCH)
        begin
            if (cmd_reg == CMD_UPDATE && hit && !ok_reg)
            begin
                ram_we = 1'b1;
            end
            else if (cmd_reg == CMD_ADD && last && found_now)
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_now;
                ram_wdata = {serial_new, req_reg};
            end
        end
    end

    plcr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CLAIMS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg[SLOT_W-1:0]),
        .rdata (rd_data)
    );

    assign rank_ctl.clear  = (state_reg == ST_RESOLVE) && !have_data;
    assign rank_ctl.sample = (state_reg == ST_RESOLVE) && have_data && valid_reg[slot_cur];

    plcr_rank u_rank (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (rank_ctl),
        .cand_req    (rd_req),
        .cand_serial (rd_serial),
        .best        (best)
    );

    always_comb
    begin
        resolved_next = '0;
        resolved_next[27:24] = best.found[LANE_STYLE] ?
                               best.req[LANE_STYLE][27:24] : base_style_reg;
        resolved_next[23:20] = best.found[LANE_MODE] ?
                               best.req[LANE_MODE][23:20] : base_mode_reg;
        resolved_next[19:16] = best.found[LANE_SHOULDER] ?
                               best.req[LANE_SHOULDER][19:16] : base_shoulder_reg;
        if (best.found[LANE_OWNER])
        begin
            resolved_next[31:28] = best.req[LANE_OWNER][31:28];
            resolved_next[15:0]  = best.req[LANE_OWNER][15:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_ADD)
                    begin
                        state_next = ST_MATCH;
                    end
                    else if ((command == CMD_RELEASE || command == CMD_UPDATE)
                             && handle != 32'd0)
                    begin
                        state_next = ST_MATCH;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_MATCH:
            begin
                if (last)
                begin
                    state_next = ok_now ? ST_RESOLVE : ST_FINISH;
                end
            end
            ST_RESOLVE:
            begin
                if (last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            valid_reg         <= '0;
            serial_reg        <= '0;
            resolved_reg      <= '0;
            revision_reg      <= '0;
            base_style_reg    <= '0;
            base_mode_reg     <= '0;
            base_shoulder_reg <= '0;
            res_valid_reg     <= 1'b0;
            found_reg         <= 1'b0;
            ok_reg            <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (paddr[3:2])
                    REG_BASE_STYLE:    base_style_reg    <= pwdata[3:0];
                    REG_BASE_MODE:     base_mode_reg     <= pwdata[3:0];
                    REG_BASE_SHOULDER: base_shoulder_reg <= pwdata[3:0];
                    default:           ;
                endcase
            end

            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    ok_reg    <= 1'b0;
                end
                ST_MATCH:
                begin
                    cnt_reg <= last ? CNT_W'(0) : cnt_reg + CNT_W'(1);
                    if (cmd_reg == CMD_RELEASE && hit)
                    begin
                        valid_reg[slot_cur] <= 1'b0;
                    end
                    if (cmd_reg == CMD_ADD && !found_reg && have_data && !valid_reg[slot_cur])
                    begin
                        found_reg <= 1'b1;
                    end
                    ok_reg <= ok_now;
                    if (last && cmd_reg == CMD_ADD && found_now)
                    begin
                        valid_reg[slot_now] <= 1'b1;
                        serial_reg          <= serial_new;
                    end
                end
                ST_RESOLVE:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                ST_FINISH:
                begin
                    res_valid_reg <= 1'b1;
                    if (ok_reg && resolved_next != resolved_reg)
                    begin
                        resolved_reg <= resolved_next;
                        revision_reg <= revision_reg + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg    <= command;
                    handle_reg <= handle;
                    req_reg    <= {priority_req, style, mode, shoulder, reason};
                    issued_reg <= '0;
                    stat_reg   <= ((command == CMD_RELEASE || command == CMD_UPDATE)
                                   && handle == 32'd0) ? STAT_INVALID : STAT_OK;
                end
            end
            ST_MATCH:
            begin
                if (cmd_reg == CMD_ADD && !found_reg && have_data && !valid_reg[slot_cur])
                begin
                    slot_reg <= slot_cur;
                end
                if (last)
                begin
                    if (ok_now)
                    begin
                        if (cmd_reg == CMD_ADD)
                        begin
                            issued_reg <= serial_new;
                        end
                    end
                    else
                    begin
                        stat_reg <= (cmd_reg == CMD_ADD) ? STAT_FULL : STAT_NOT_FOUND;
                    end
                end
            end
            ST_FINISH:
            begin
                res_status_reg  <= stat_reg;
                res_handle_reg  <= issued_reg;
                res_changed_reg <= ok_reg && (resolved_next != resolved_reg);
            end
            default: ;
        endcase
    end

    assign res_valid      = res_valid_reg;
    assign status         = res_status_reg;
    assign new_handle     = res_handle_reg;
    assign changed        = res_changed_reg;
    assign revision       = revision_reg;
    assign out_style      = resolved_reg[27:24];
    assign out_mode       = resolved_reg[23:20];
    assign out_shoulder   = resolved_reg[19:16];
    assign owner_priority = resolved_reg[31:28];
    assign owner_reason   = resolved_reg[15:0];

    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[3:2])
            REG_BASE_STYLE:    prdata = {28'd0, base_style_reg};
            REG_BASE_MODE:     prdata = {28'd0, base_mode_reg};
            REG_BASE_SHOULDER: prdata = {28'd0, base_shoulder_reg};
            default:           prdata = 32'd0;
        endcase
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("sequencer idle after accepting a command beat");

    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !res_valid_reg)
        else $error("result beat pending while a command is in progress");

    a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_status_reg != STAT_OK)
        |-> (!res_changed_reg && res_handle_reg == 32'd0))
        else $error("failed command reports a change or an issued handle");

    a_revision_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && ok_reg && resolved_next != resolved_reg)
        |=> (revision_reg == $past(revision_reg) + 32'd1))
        else $error("revision did not advance on a resolved-state change");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for priority_layered_claim_resolver: claim commands against an
// in-bench claim table that predicts every result beat, plus APB base register writes.
// Depends on plcr_pkg and the RTL top level only.
module tb;
    import plcr_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_START   = 20000;
    localparam int HOLD_LEN     = 400;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 400;
    localparam int SETTLE       = 2 * MAX_CLAIMS + 8;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] handle;
        logic [3:0]  pri;
        logic [3:0]  sty;
        logic [3:0]  mod;
        logic [3:0]  sho;
        logic [15:0] rsn;
    } claim_cmd_t;

    // same packing as the resolved state: priority, style, mode, shoulder, reason
    typedef struct packed {
        logic [3:0]  pri;
        logic [3:0]  sty;
        logic [3:0]  mod;
        logic [3:0]  sho;
        logic [15:0] rsn;
    } claim_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] issued;
        logic [3:0]  sty;
        logic [3:0]  mod;
        logic [3:0]  sho;
        logic [3:0]  own_pri;
        logic [15:0] own_rsn;
        logic        chg;
        logic [31:0] rev;
    } resolution_t;

    typedef struct {
        claim_cmd_t  beat;
        bit          typed;
        resolution_t want;
    } script_row_t;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  command;
    logic [31:0] handle;
    logic [3:0]  priority_req;
    logic [3:0]  style;
    logic [3:0]  mode;
    logic [3:0]  shoulder;
    logic [15:0] reason;
    logic        res_valid;
    logic        res_stall;
    logic [1:0]  status;
    logic [31:0] new_handle;
    logic [3:0]  out_style;
    logic [3:0]  out_mode;
    logic [3:0]  out_shoulder;
    logic [3:0]  owner_priority;
    logic [15:0] owner_reason;
    logic        changed;
    logic [31:0] revision;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    priority_layered_claim_resolver dut (.*);

    // claim table mirror
    bit          slot_live   [MAX_CLAIMS];
    logic [31:0] slot_serial [MAX_CLAIMS];
    claim_req_t  slot_req    [MAX_CLAIMS];
    logic [31:0] last_serial;
    claim_req_t  settled;
    logic [31:0] revision_count;
    logic [3:0]  base_sty;
    logic [3:0]  base_mod;
    logic [3:0]  base_sho;

    resolution_t expected_results[$];

    bit calm;
    int mismatches;
    int cycle_count;
    int n_commands;
    int n_issued;
    int n_full;
    int n_missing;
    int n_invalid;
    int n_changes;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %0s: got %0h, want %0h at %0t", what, got, want, $time);
    endtask

    function automatic logic [3:0] lane_of(claim_req_t r, int lane);
        case (lane)
            LANE_STYLE:    return r.sty;
            LANE_MODE:     return r.mod;
            LANE_SHOULDER: return r.sho;
            default:       return r.pri;
        endcase
    endfunction

    // Higher priority wins, then the later serial; on a full tie the lower slot stays.
    function automatic int strongest_slot(int lane);
        int best;
        best = -1;
        for (int i = 0; i < MAX_CLAIMS; i++)
        begin
            if (!slot_live[i])
                continue;
            if (lane != LANE_OWNER && lane_of(slot_req[i], lane) == 4'd0)
                continue;
            if (best < 0)
                best = i;
            else if (slot_req[i].pri > slot_req[best].pri)
                best = i;
            else if (slot_req[i].pri == slot_req[best].pri
                     && slot_serial[i] > slot_serial[best])
                best = i;
        end
        return best;
    endfunction

    function automatic logic [3:0] lane_pick(int lane, logic [3:0] base);
        int k;
        k = strongest_slot(lane);
        return (k < 0) ? base : lane_of(slot_req[k], lane);
    endfunction

    function automatic claim_req_t resolve_claims();
        claim_req_t r;
        int         own;
        r.sty = lane_pick(LANE_STYLE, base_sty);
        r.mod = lane_pick(LANE_MODE, base_mod);
        r.sho = lane_pick(LANE_SHOULDER, base_sho);
        own = strongest_slot(LANE_OWNER);
        r.pri = (own < 0) ? 4'd0 : slot_req[own].pri;
        r.rsn = (own < 0) ? 16'd0 : slot_req[own].rsn;
        return r;
    endfunction

    function automatic resolution_t apply_command(claim_cmd_t c);
        resolution_t res;
        claim_req_t  req;
        claim_req_t  next;
        int          slot;
        bit          ok;
        res = '0;
        ok = 1'b0;
        slot = -1;
        req = {c.pri, c.sty, c.mod, c.sho, c.rsn};
        res.status = STAT_OK;
        case (c.command)
            CMD_ADD:
            begin
                for (int i = MAX_CLAIMS - 1; i >= 0; i--)
                    if (!slot_live[i])
                        slot = i;
                if (slot < 0)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    // the serial never takes the value zero
                    last_serial = last_serial + 32'd1;
                    if (last_serial == 32'd0)
                        last_serial = 32'd1;
                    slot_live[slot] = 1'b1;
                    slot_serial[slot] = last_serial;
                    slot_req[slot] = req;
                    res.issued = last_serial;
                    ok = 1'b1;
                end
            end
            CMD_RELEASE, CMD_UPDATE:
            begin
                if (c.handle == 32'd0)
                begin
                    res.status = STAT_INVALID;
                end
                else
                begin
                    // release drops every holder of the handle, update only the lowest
                    for (int i = 0; i < MAX_CLAIMS; i++)
                        if (slot_live[i] && slot_serial[i] == c.handle
                            && !(ok && c.command == CMD_UPDATE))
                        begin
                            if (c.command == CMD_RELEASE)
                                slot_live[i] = 1'b0;
                            else
                                slot_req[i] = req;
                            ok = 1'b1;
                        end
                    if (!ok)
                        res.status = STAT_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        if (ok)
        begin
            next = resolve_claims();
            if (next != settled)
            begin
                settled = next;
                revision_count = revision_count + 32'd1;
                res.chg = 1'b1;
            end
        end
        res.sty = settled.sty;
        res.mod = settled.mod;
        res.sho = settled.sho;
        res.own_pri = settled.pri;
        res.own_rsn = settled.rsn;
        res.rev = revision_count;
        return res;
    endfunction

    // Mostly well-formed traffic on live handles, with some stale, zero and odd commands.
    function automatic claim_cmd_t random_claim();
        claim_cmd_t  c;
        logic [31:0] live_handles[$];
        int          roll;
        for (int i = 0; i < MAX_CLAIMS; i++)
            if (slot_live[i])
                live_handles.push_back(slot_serial[i]);
        c.handle = $urandom();
        c.pri = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        c.sty = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15));
        c.mod = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15));
        c.sho = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15));
        c.rsn = 16'($urandom_range(0, 65535));
        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            c.command = CMD_ADD;
        end
        else if (roll < 88)
        begin
            c.command = (roll < 65) ? CMD_RELEASE : CMD_UPDATE;
            if (live_handles.size() != 0)
                c.handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
        end
        else if (roll < 93)
        begin
            c.command = $urandom_range(0, 1) ? CMD_RELEASE : CMD_UPDATE;
            if ($urandom_range(0, 1) && last_serial != 32'd0)
                c.handle = $urandom_range(1, last_serial);
        end
        else if (roll < 97)
        begin
            c.command = $urandom_range(0, 1) ? CMD_RELEASE : CMD_UPDATE;
            c.handle = 32'd0;
        end
        else
        begin
            c.command = CMD_UNKNOWN;
        end
        return c;
    endfunction

    task automatic send_claim(input claim_cmd_t c, input bit typed, input resolution_t want);
        resolution_t guess;
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 47)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command <= c.command;
        handle <= c.handle;
        priority_req <= c.pri;
        style <= c.sty;
        mode <= c.mod;
        shoulder <= c.sho;
        reason <= c.rsn;
        do @(posedge clk); while (cmd_stall);
        guess = apply_command(c);
        expected_results.push_back(typed ? want : guess);
        n_commands++;
        if (guess.issued != 32'd0)
            n_issued++;
        if (guess.chg)
            n_changes++;
        case (guess.status)
            STAT_FULL:      n_full++;
            STAT_NOT_FOUND: n_missing++;
            STAT_INVALID:   n_invalid++;
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_cycle(input bit wr, input logic [1:0] idx, input logic [3:0] val,
                             output logic [31:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= {28'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [3:0] val);
        logic [31:0] rd;
        apb_cycle(1'b1, idx, val, rd);
        case (idx)
            REG_BASE_STYLE: base_sty = val;
            REG_BASE_MODE:  base_mod = val;
            default:        base_sho = val;
        endcase
        apb_cycle(1'b0, idx, 4'd0, rd);
        if (rd != {28'd0, val})
            report_mismatch("register read back", rd, {28'd0, val});
    endtask

    task automatic check_result(input resolution_t want);
        if (status != want.status)             report_mismatch("status", status, want.status);
        if (new_handle != want.issued)         report_mismatch("new_handle", new_handle,
                                                               want.issued);
        if (out_style != want.sty)             report_mismatch("out_style", out_style, want.sty);
        if (out_mode != want.mod)              report_mismatch("out_mode", out_mode, want.mod);
        if (out_shoulder != want.sho)          report_mismatch("out_shoulder", out_shoulder,
                                                               want.sho);
        if (owner_priority != want.own_pri)    report_mismatch("owner_priority", owner_priority,
                                                               want.own_pri);
        if (owner_reason != want.own_rsn)      report_mismatch("owner_reason", owner_reason,
                                                               want.own_rsn);
        if (changed != want.chg)               report_mismatch("changed", changed, want.chg);
        if (revision != want.rev)              report_mismatch("revision", revision, want.rev);
    endtask

    initial
    begin : sink
        int cycles_seen;
        cycles_seen = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycles_seen++;
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result beat with nothing pending", status, 32'd0);
                else
                    check_result(expected_results.pop_front());
            end
            // one long hold so the block backs up onto its command side
            if (cycles_seen >= HOLD_START && cycles_seen < HOLD_START + HOLD_LEN)
                res_stall <= 1'b1;
            else if (calm)
                res_stall <= 1'b0;
            else
                res_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    initial
    begin : stimulus
        script_row_t script[$];
        resolution_t none;
        claim_cmd_t  fill;
        none = '0;
        calm = 1'b0;
        rst_n <= 1'b0;
        cmd_valid <= 1'b0;
        command <= CMD_ADD;
        handle <= 32'd0;
        priority_req <= 4'd0;
        style <= 4'd0;
        mode <= 4'd0;
        shoulder <= 4'd0;
        reason <= 16'd0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 4'd0;
        pwdata <= 32'd0;
        for (int i = 0; i < MAX_CLAIMS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_serial[i] = 32'd0;
            slot_req[i] = '0;
        end
        last_serial = 32'd0;
        settled = '0;
        revision_count = 32'd0;
        base_sty = 4'd0;
        base_mod = 4'd0;
        base_sho = 4'd0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        reg_write(REG_BASE_STYLE, 4'd0);
        reg_write(REG_BASE_MODE, 4'd0);
        reg_write(REG_BASE_SHOULDER, 4'd0);

        // error answers on an empty table, then the extremes of a claim
        script.push_back('{'{CMD_RELEASE, 32'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0}, 1'b1,
                           '{STAT_INVALID, 32'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0, 1'b0, 32'd0}});
        script.push_back('{'{CMD_UPDATE, 32'd0, 4'hF, 4'hF, 4'hF, 4'hF, 16'hFFFF}, 1'b1,
                           '{STAT_INVALID, 32'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0, 1'b0, 32'd0}});
        script.push_back('{'{CMD_RELEASE, 32'hFFFF_FFFF, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0}, 1'b1,
                           '{STAT_NOT_FOUND, 32'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0, 1'b0, 32'd0}});
        script.push_back('{'{CMD_UPDATE, 32'd1, 4'd3, 4'd3, 4'd3, 4'd3, 16'd3}, 1'b1,
                           '{STAT_NOT_FOUND, 32'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0, 1'b0, 32'd0}});
        script.push_back('{'{CMD_UNKNOWN, 32'd1, 4'hF, 4'hF, 4'hF, 4'hF, 16'hFFFF}, 1'b1,
                           '{STAT_OK, 32'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0, 1'b0, 32'd0}});
        script.push_back('{'{CMD_ADD, 32'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0}, 1'b1,
                           '{STAT_OK, 32'd1, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0, 1'b0, 32'd0}});
        script.push_back('{'{CMD_ADD, 32'd0, 4'hF, 4'hF, 4'hF, 4'hF, 16'hFFFF}, 1'b1,
                           '{STAT_OK, 32'd2, 4'hF, 4'hF, 4'hF, 4'hF, 16'hFFFF, 1'b1, 32'd1}});
        // equal priority: the later serial takes style and ownership
        script.push_back('{'{CMD_ADD, 32'd0, 4'hF, 4'd3, 4'd0, 4'd0, 16'h1234}, 1'b0, none});
        script.push_back('{'{CMD_UPDATE, 32'd2, 4'hF, 4'd0, 4'd7, 4'd0, 16'd5}, 1'b0, none});
        script.push_back('{'{CMD_UPDATE, 32'd3, 4'd1, 4'd9, 4'd9, 4'd9, 16'hAAAA}, 1'b0, none});
        script.push_back('{'{CMD_RELEASE, 32'd3, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0}, 1'b0, none});
        for (int k = 0; k < MAX_CLAIMS - 2; k++)
        begin
            fill = '{CMD_ADD, 32'h5555_5555, 4'(k * 3), (k % 2) ? 4'h5 : 4'hA,
                     (k % 2) ? 4'd0 : 4'h3, 4'(k), 16'h5555 ^ 16'(k)};
            script.push_back('{fill, 1'b0, none});
        end
        // table now full
        script.push_back('{'{CMD_ADD, 32'hAAAA_AAAA, 4'hF, 4'h1, 4'h1, 4'h1, 16'h0F0F}, 1'b0, none});
        script.push_back('{'{CMD_UPDATE, 32'hFFFF_FFFF, 4'd2, 4'd2, 4'd2, 4'd2, 16'd2}, 1'b0, none});
        script.push_back('{'{CMD_RELEASE, 32'd1, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0}, 1'b0, none});
        // takes the lowest free slot
        script.push_back('{'{CMD_ADD, 32'd0, 4'd7, 4'd0, 4'hC, 4'd0, 16'h8000}, 1'b0, none});
        script.push_back('{'{CMD_RELEASE, 32'd1, 4'd0, 4'd0, 4'd0, 4'd0, 16'd0}, 1'b0, none});
        script.push_back('{'{CMD_UPDATE, 32'h8000_0000, 4'd1, 4'd1, 4'd1, 4'd1, 16'd1}, 1'b0,
                           none});

        foreach (script[i])
            send_claim(script[i].beat, script[i].typed, script[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    reg_write(REG_BASE_STYLE, 4'hF);
                    reg_write(REG_BASE_MODE, 4'hF);
                    reg_write(REG_BASE_SHOULDER, 4'hF);
                end
                1:
                begin
                    reg_write(REG_BASE_STYLE, 4'h0);
                    reg_write(REG_BASE_MODE, 4'h0);
                    reg_write(REG_BASE_SHOULDER, 4'h0);
                end
                default:
                begin
                    reg_write(REG_BASE_STYLE, 4'($urandom_range(0, 15)));
                    reg_write(REG_BASE_MODE, 4'($urandom_range(0, 15)));
                    reg_write(REG_BASE_SHOULDER, 4'($urandom_range(0, 15)));
                end
            endcase
            // no random idling on either side for the whole of phase 2
            calm = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_claim(random_claim(), 1'b0, none);
        end
        calm = 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("ran %0d claim commands over %0d base settings: %0d handles issued",
                 n_commands, PHASES + 1, n_issued);
        $display("answers: %0d table full, %0d unknown handle, %0d zero handle; %0d changes",
                 n_full, n_missing, n_invalid, n_changes);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> priority_layered_claim_resolver.f
hw/rtl/plcr_pkg.sv
hw/rtl/plcr_ram.sv
hw/rtl/plcr_rank.sv
hw/rtl/priority_layered_claim_resolver.sv
tb/sv/tb.sv
